// File: src/assert_macros.svh
// Assertion macros shared by the averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

// File: src/cla_pkg.sv
// Shared types and constants of the coherent line averager.
`timescale 1ns / 1ps
package cla_pkg;

  // Sizes of the stream and of the accumulator store.
  localparam int MAX_LINE_SAMPLES = 4096;
  localparam int IDX_W    = $clog2(MAX_LINE_SAMPLES);
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 26;
  localparam int LEN_W    = 13;
  localparam int PASS_W   = 10;
  localparam int STEP_W   = $clog2(SUM_W + 1);

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [LEN_W-1:0]  LEN_RESET   = 13'd4096;
  localparam logic [PASS_W-1:0] CNT_RESET   = 10'd1;
  localparam logic [PASS_W-1:0] COUNT_LIMIT = 10'd1000;

  // Register index codes, taken from paddr[2].
  typedef enum logic {
    REG_LINE_LENGTH   = 1'b0,
    REG_AVERAGE_COUNT = 1'b1
  } reg_idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_PUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic update;
    logic div_start;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_pass;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// File: src/cla_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module cla_div
  import cla_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic        [PASS_W-1:0]   divisor,
  output logic                       busy,
  output logic signed [SAMPLE_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [PASS_W-1:0] rem_r, rem_nxt;
  logic [PASS_W-1:0] div_r, div_nxt;
  logic              neg_r, neg_nxt;
  logic [PASS_W:0]   rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  q_signed;

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  always_comb begin
    rem_sh   = {rem_r, q_r[SUM_W-1]};
    ge       = (rem_sh >= {1'b0, div_r});
    busy_nxt = busy_r;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W);
      q_nxt    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_nxt  = '0;
      div_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
    end else if (busy_r) begin
      q_nxt    = {q_r[SUM_W-2:0], ge};
      rem_nxt  = ge ? PASS_W'(rem_sh - {1'b0, div_r}) : rem_sh[PASS_W-1:0];
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  // Restore the sign; the mean always fits the sample width.
  assign q_signed = neg_r ? SUM_W'(-q_r) : q_r;
  assign quotient = q_signed[SAMPLE_W-1:0];
  assign busy     = busy_r;

endmodule

// File: src/cla_datapath.sv
// Datapath: configuration registers, position indices, sum store, divider, result register.
`timescale 1ns / 1ps
module cla_datapath
  import cla_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  logic signed [SAMPLE_W-1:0] in_rf_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_averaged_sample,
  output logic                       out_line_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata
);

  logic [LEN_W-1:0]  line_length_r, line_length_nxt;
  logic [PASS_W-1:0] average_count_r, average_count_nxt;
  logic [LEN_W-1:0]  len;
  logic [PASS_W-1:0] cnt;
  logic              cfg_wr;
  reg_idx_t          reg_idx;

  logic [IDX_W-1:0]  sample_index_r, sample_index_nxt;
  logic [PASS_W-1:0] pass_index_r, pass_index_nxt;
  logic [IDX_W-1:0]  eff_idx;
  logic [PASS_W-1:0] eff_pass;
  logic [IDX_W:0]    idx_inc;
  logic [PASS_W:0]   pass_inc;
  logic              wrap;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [IDX_W-1:0]  idx_r;
  logic              first_r, last_r, line_end_r;
  logic              last_nxt, line_end_nxt;

  logic signed [SUM_W-1:0] sums_mem [MAX_LINE_SAMPLES];
  logic signed [SUM_W-1:0] rd_r;
  logic signed [SUM_W-1:0] sum_nxt;

  logic                       div_busy;
  logic signed [SAMPLE_W-1:0] quotient;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_line_end_r;

  // Configuration writes complete in the access phase.
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    line_length_nxt   = line_length_r;
    average_count_nxt = average_count_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_LINE_LENGTH:   line_length_nxt   = pwdata[LEN_W-1:0];
        REG_AVERAGE_COUNT: average_count_nxt = pwdata[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LINE_LENGTH:   prdata = DATA_W'(line_length_r);
      REG_AVERAGE_COUNT: prdata = DATA_W'(average_count_r);
      default:           prdata = '0;
    endcase
  end

  // Effective line length and repeat count after clamping.
  always_comb begin
    if (line_length_r == '0) begin
      len = LEN_W'(1);
    end else if (32'(line_length_r) > 32'(MAX_LINE_SAMPLES)) begin
      len = LEN_W'(MAX_LINE_SAMPLES);
    end else begin
      len = line_length_r;
    end
    if (average_count_r == '0) begin
      cnt = PASS_W'(1);
    end else if (average_count_r > COUNT_LIMIT) begin
      cnt = COUNT_LIMIT;
    end else begin
      cnt = average_count_r;
    end
  end

  // Position and pass of the incoming beat, and where the next one lands.
  always_comb begin
    eff_idx  = (32'(sample_index_r) >= 32'(len)) ? '0 : sample_index_r;
    eff_pass = (pass_index_r >= cnt) ? '0 : pass_index_r;
    idx_inc  = {1'b0, eff_idx} + (IDX_W+1)'(1);
    pass_inc = {1'b0, eff_pass} + (PASS_W+1)'(1);
    wrap     = (32'(idx_inc) >= 32'(len));
    last_nxt     = (eff_pass == cnt - PASS_W'(1));
    line_end_nxt = (32'(eff_idx) == 32'(len) - 32'd1);
    sample_index_nxt = sample_index_r;
    pass_index_nxt   = pass_index_r;
    if (cmd.load) begin
      sample_index_nxt = wrap ? '0 : idx_inc[IDX_W-1:0];
      if (wrap) begin
        pass_index_nxt = (pass_inc >= {1'b0, cnt}) ? '0 : pass_inc[PASS_W-1:0];
      end else begin
        pass_index_nxt = eff_pass;
      end
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r   <= LEN_RESET;
      average_count_r <= CNT_RESET;
      sample_index_r  <= '0;
      pass_index_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      line_length_r   <= line_length_nxt;
      average_count_r <= average_count_nxt;
      sample_index_r  <= sample_index_nxt;
      pass_index_r    <= pass_index_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Capture the accepted beat and its position flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r   <= in_rf_sample;
      idx_r      <= eff_idx;
      first_r    <= (eff_pass == '0);
      last_r     <= last_nxt;
      line_end_r <= line_end_nxt;
    end
  end

  // New running sum: the first pass stores the sample, later passes add it.
  assign sum_nxt = first_r ? SUM_W'(sample_r) : rd_r + SUM_W'(sample_r);

  // Sum store: read on accept, written back in the cycle after.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      sums_mem[idx_r] <= sum_nxt;
    end
    rd_r <= sums_mem[eff_idx];
  end

  cla_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_nxt),
    .divisor  (cnt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Result register: loaded on push, emptied when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_sample_r   <= quotient;
      out_line_end_r <= line_end_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_averaged_sample = out_sample_r;
  assign out_line_end        = out_line_end_r;

  assign stat.last_pass = last_r;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

// File: src/cla_ctrl.sv
// Controller state machine sequencing accept, store update, division and result push.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cla_ctrl
  import cla_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt = stat.last_pass ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_UPDATE: begin
        cmd.update    = 1'b1;
        cmd.div_start = stat.last_pass;
      end
      S_DIV: ;
      S_PUSH: begin
        cmd.push = stat.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A pending result is never overwritten.
  `ASSERT_PROP(a_push_free, clk, rst_n, cmd.push |-> stat.out_free)
  // The divider is only started when it is idle.
  `ASSERT_NEVER(a_start_busy, clk, rst_n, cmd.div_start && stat.div_busy)
  // A started division keeps the divider busy on the next cycle.
  `ASSERT_PROP(a_div_runs, clk, rst_n, cmd.div_start |=> stat.div_busy)

endmodule

// File: src/coherent_line_averager.sv
// Top level of the coherent line averager.
`timescale 1ns / 1ps
// Coherent averaging of repeated RF lines. Signed samples arrive line after
// line; each line is repeated average_count times and one running sum is kept
// per sample position in a 4096-entry store. Passes before the last give no
// result; on the last pass each position gives its sum divided by the count,
// truncated toward zero, with out_line_end set on the final sample of the
// line. Samples are taken one at a time: a sample of an earlier pass takes a
// store read, then an add and write back; a sample of the last pass then also
// runs the one-bit-per-cycle divider over the 26-bit sum and waits for the
// result register while it still holds an untaken result. The result register
// lets a new sample in while the previous result waits. The store needs no
// clearing after reset; register writes leave the indices and sums untouched.
module coherent_line_averager
  import cla_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_rf_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_averaged_sample,
  output logic                       out_line_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  cla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cla_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_rf_sample        (in_rf_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_averaged_sample (out_averaged_sample),
    .out_line_end        (out_line_end),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata)
  );

endmodule
